// ===== rtl/core/vdrc_pkg.sv =====
// Shared constants, types and address helper for the voxel depth ray caster.
`default_nettype none

package vdrc_pkg;

  localparam int MAP_WIDTH  = 32;
  localparam int MAP_HEIGHT = 32;
  localparam int MAP_DEPTH  = 32;

  localparam int X_W       = $clog2(MAP_WIDTH);
  localparam int Y_W       = $clog2(MAP_HEIGHT);
  localparam int Z_W       = $clog2(MAP_DEPTH);
  localparam int MEM_DEPTH = MAP_WIDTH * MAP_HEIGHT * MAP_DEPTH;
  localparam int ADDR_W    = $clog2(MEM_DEPTH);

  localparam int COLOR_W    = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 7;

  localparam logic [CFG_IDX_W-1:0] REG_VIEW_X   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VIEW_Y   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VIEW_Z   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_VIEW_DIR = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HORIZON  = 3'd4;

  localparam logic [1:0] DIR_FRONT = 2'd0;
  localparam logic [1:0] DIR_BACK  = 2'd1;
  localparam logic [1:0] DIR_LEFT  = 2'd2;
  localparam logic [1:0] DIR_RIGHT = 2'd3;

  localparam logic ACT_WRITE  = 1'b0;
  localparam logic ACT_RENDER = 1'b1;

  typedef struct packed {
    logic               en;
    logic [ADDR_W-1:0]  addr;
    logic [COLOR_W-1:0] data;
  } vdrc_wr_t;

  function automatic logic [ADDR_W-1:0] voxel_addr(logic [X_W-1:0] x, logic [Y_W-1:0] y,
                                                   logic [Z_W-1:0] z);
    return ADDR_W'((32'(z) * MAP_HEIGHT + 32'(y)) * MAP_WIDTH + 32'(x));
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/voxel_depth_ray_caster.sv =====
// Top level of the voxel depth ray caster: configuration, march control and output register.
`default_nettype none

// A write transfer stores one voxel and returns nothing. A render transfer first sets up the
// march, then reads the voxel memory once per cycle along the viewing axis, up to limit + 1
// cells, where limit is the smaller of horizon - 1 and the room to the map edge; a cell
// outside the map gives a zero result with no march. The single read port of the voxel
// memory sets the pace of the march. A finished render waits while the previous result has
// not been taken, so a low out_ready adds its cycles to the render. After reset the memory is
// swept to zero, one entry a cycle, over all 32768 entries, during which no item is accepted.
module voxel_depth_ray_caster (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [vdrc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [vdrc_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic                              action,
  input  wire logic [4:0]                        vox_x,
  input  wire logic [4:0]                        vox_y,
  input  wire logic [4:0]                        vox_z,
  input  wire logic [7:0]                        vox_color,
  input  wire logic signed [6:0]                 row_offset,
  input  wire logic signed [6:0]                 col_offset,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [7:0]                             pixel_color
);
  import vdrc_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_MARCH, ST_DONE} state_t;

  localparam logic signed [9:0] WIDTH_S   = 10'(MAP_WIDTH);
  localparam logic signed [9:0] HEIGHT_S  = 10'(MAP_HEIGHT);
  localparam logic signed [9:0] DEPTH_S   = 10'(MAP_DEPTH);

  state_t             state;
  logic [4:0]         view_x;
  logic [4:0]         view_y;
  logic [4:0]         view_z;
  logic [1:0]         view_dir;
  logic [6:0]         horizon;
  logic [X_W-1:0]     cur_x;
  logic [Y_W-1:0]     cur_y;
  logic [Z_W-1:0]     cur_z;
  logic [1:0]         dir;
  logic [7:0]         steps_left;
  logic               last_sent;
  logic               rd_valid;
  logic               rd_last;
  logic [COLOR_W-1:0] result;

  logic               clearing;
  logic [COLOR_W-1:0] rd_data;
  vdrc_wr_t           wr;
  logic               in_xfer;
  logic               issue;

  logic signed [9:0]  ry;
  logic signed [9:0]  rx;
  logic signed [9:0]  rz;
  logic signed [9:0]  room;
  logic [6:0]         lim;
  logic [7:0]         start_steps;
  logic               in_map;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == ST_IDLE) && !clearing;
  assign in_xfer   = in_valid && in_ready;
  assign issue     = (state == ST_MARCH) && !last_sent;

  always_ff @(posedge clk) begin
    if (rst) begin
      view_x   <= '0;
      view_y   <= '0;
      view_z   <= '0;
      view_dir <= DIR_FRONT;
      horizon  <= 7'd16;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_VIEW_X:   view_x   <= cfg_data[4:0];
        REG_VIEW_Y:   view_y   <= cfg_data[4:0];
        REG_VIEW_Z:   view_z   <= cfg_data[4:0];
        REG_VIEW_DIR: view_dir <= cfg_data[1:0];
        REG_HORIZON:  horizon  <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    ry = $signed({5'b0, view_y}) + 10'(row_offset);
    if (view_dir == DIR_FRONT || view_dir == DIR_BACK) begin
      rx = $signed({5'b0, view_x}) + 10'(col_offset);
      rz = $signed({5'b0, view_z});
    end else begin
      rx = $signed({5'b0, view_x});
      rz = $signed({5'b0, view_z}) + 10'(col_offset);
    end
    case (view_dir)
      DIR_FRONT: room = DEPTH_S - 10'sd1 - rz;
      DIR_BACK:  room = rz;
      DIR_LEFT:  room = rx;
      DIR_RIGHT: room = WIDTH_S - 10'sd1 - rx;
      default:   room = rz;
    endcase
    in_map = (ry >= 10'sd0) && (ry < HEIGHT_S) && (rx >= 10'sd0) && (rx < WIDTH_S)
             && (rz >= 10'sd0) && (rz < DEPTH_S);
    lim = (horizon == 7'd0) ? 7'd0 : horizon - 7'd1;
    if (room < $signed({3'b0, lim})) begin
      start_steps = room[7:0];
    end else begin
      start_steps = {1'b0, lim};
    end
  end

  always_comb begin
    wr.en   = in_xfer && (action == ACT_WRITE) && (32'(vox_x) < 32'(MAP_WIDTH))
              && (32'(vox_y) < 32'(MAP_HEIGHT)) && (32'(vox_z) < 32'(MAP_DEPTH));
    wr.addr = voxel_addr(X_W'(vox_x), Y_W'(vox_y), Z_W'(vox_z));
    wr.data = vox_color;
  end

  vdrc_voxel_mem u_mem (
    .clk      (clk),
    .rst      (rst),
    .wr       (wr),
    .rd_addr  (voxel_addr(cur_x, cur_y, cur_z)),
    .rd_data  (rd_data),
    .clearing (clearing)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      rd_valid  <= 1'b0;
      rd_last   <= 1'b0;
      last_sent <= 1'b0;
    end else begin
      if (state == ST_DONE && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_xfer && action == ACT_RENDER) begin
            cur_x      <= X_W'(rx[7:0]);
            cur_y      <= Y_W'(ry[7:0]);
            cur_z      <= Z_W'(rz[7:0]);
            dir        <= view_dir;
            steps_left <= start_steps;
            last_sent  <= 1'b0;
            rd_valid   <= 1'b0;
            rd_last    <= 1'b0;
            if (in_map) begin
              state <= ST_MARCH;
            end else begin
              result <= '0;
              state  <= ST_DONE;
            end
          end
        end
        ST_MARCH: begin
          rd_last  <= issue && (steps_left == 8'd0);
          if (issue) begin
            if (steps_left == 8'd0) begin
              last_sent <= 1'b1;
            end else begin
              steps_left <= steps_left - 8'd1;
              case (dir)
                DIR_FRONT: cur_z <= cur_z + Z_W'(1);
                DIR_BACK:  cur_z <= cur_z - Z_W'(1);
                DIR_LEFT:  cur_x <= cur_x - X_W'(1);
                DIR_RIGHT: cur_x <= cur_x + X_W'(1);
                default:   cur_z <= cur_z;
              endcase
            end
          end
          if (rd_valid && (rd_data != '0 || rd_last)) begin
            result   <= rd_data;
            rd_valid <= 1'b0;
            state    <= ST_DONE;
          end else begin
            rd_valid <= issue;
          end
        end
        ST_DONE: begin
          if (!out_valid || out_ready) begin
            pixel_color <= result;
            state       <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !in_ready)
    else $error("Input accepted during the memory clearing sweep.");

  a_read_only_in_march: assert property (@(posedge clk) disable iff (rst)
    rd_valid |-> $past(state == ST_MARCH))
    else $error("Voxel read tracked outside of a march.");

  a_render_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && action == ACT_RENDER |=> state != ST_IDLE)
    else $error("Render transfer did not start a march.");

  a_done_reaches_output: assert property (@(posedge clk) disable iff (rst)
    state == ST_DONE && !out_valid |=> out_valid && state == ST_IDLE)
    else $error("Finished render was not moved to the output register.");

endmodule

`default_nettype wire

// ===== rtl/core/vdrc_voxel_mem.sv =====
// Voxel map memory with a clearing sweep after reset and a registered read port.
`default_nettype none

module vdrc_voxel_mem (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire vdrc_pkg::vdrc_wr_t         wr,
  input  wire logic [vdrc_pkg::ADDR_W-1:0]  rd_addr,
  output logic      [vdrc_pkg::COLOR_W-1:0] rd_data,
  output logic                            clearing
);
  import vdrc_pkg::*;

  logic [COLOR_W-1:0] mem [MEM_DEPTH];
  logic [ADDR_W-1:0]  clear_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing   <= 1'b1;
      clear_addr <= '0;
    end else if (clearing) begin
      clear_addr <= clear_addr + ADDR_W'(1);
      if (clear_addr == ADDR_W'(MEM_DEPTH - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clear_addr] <= '0;
    end else if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// ===== tb/sv/voxel_depth_ray_caster_tb.sv =====
// Self-checking testbench for the voxel depth ray caster: a directed table, then random phases.
module voxel_depth_ray_caster_tb;
  import vdrc_pkg::*;

  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int SETTLE_CYCLES = 80;
  localparam int PHASES        = 15;
  localparam int PHASE_ITEMS   = 120;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE      = REG_HORIZON + 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LAST = '1;

  typedef struct {
    logic                  is_cfg;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
    logic                  act;
    logic [4:0]            x;
    logic [4:0]            y;
    logic [4:0]            z;
    logic [7:0]            color;
    logic signed [6:0]     row;
    logic signed [6:0]     col;
    logic                  typed;
    logic [7:0]            want;
  } cast_step_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_ready;
  logic                  action;
  logic [4:0]            vox_x;
  logic [4:0]            vox_y;
  logic [4:0]            vox_z;
  logic [7:0]            vox_color;
  logic signed [6:0]     row_offset;
  logic signed [6:0]     col_offset;
  logic                  out_valid;
  logic                  out_ready;
  logic [7:0]            pixel_color;

  logic [COLOR_W-1:0] shade_map [0:MEM_DEPTH-1];
  logic [4:0]         cam_x, cam_y, cam_z;
  logic [1:0]         facing;
  logic [6:0]         horizon;

  logic [7:0]  pixel_q[$];
  cast_step_t  plan[$];
  logic        steady;
  logic        items_sent;
  int          errors, cycles, n_probes, n_hits, n_paints, n_cfg;

  voxel_depth_ray_caster u_top (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .action(action),
    .vox_x(vox_x), .vox_y(vox_y), .vox_z(vox_z), .vox_color(vox_color),
    .row_offset(row_offset), .col_offset(col_offset),
    .out_valid(out_valid), .out_ready(out_ready), .pixel_color(pixel_color)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  function automatic logic [7:0] voxel_at(input int x, input int y, input int z);
    if (x < 0 || y < 0 || z < 0 || x >= MAP_WIDTH || y >= MAP_HEIGHT || z >= MAP_DEPTH)
      return '0;
    return shade_map[(z * MAP_HEIGHT + y) * MAP_WIDTH + x];
  endfunction

  function automatic logic [7:0] cast_ray(input logic signed [6:0] row,
                                          input logic signed [6:0] col);
    int x, y, z, dx, dz, room, reach, k;
    logic [7:0] hit;
    dx = 0;
    dz = 0;
    y = int'(cam_y) + int'(row);
    if (y < 0 || y >= MAP_HEIGHT) return '0;
    if (facing == DIR_FRONT || facing == DIR_BACK) begin
      x = int'(cam_x) + int'(col);
      z = int'(cam_z);
      dz = (facing == DIR_FRONT) ? 1 : -1;
      room = (facing == DIR_FRONT) ? MAP_DEPTH - 1 - z : z;
    end else begin
      x = int'(cam_x);
      z = int'(cam_z) + int'(col);
      dx = (facing == DIR_RIGHT) ? 1 : -1;
      room = (facing == DIR_RIGHT) ? MAP_WIDTH - 1 - x : x;
    end
    if (x < 0 || x >= MAP_WIDTH || z < 0 || z >= MAP_DEPTH) return '0;
    reach = (horizon == 0) ? 0 : int'(horizon) - 1;
    if (room < reach) reach = room;
    hit = voxel_at(x, y, z);
    for (k = 1; k <= reach && hit == 0; k++) hit = voxel_at(x + dx * k, y, z + dz * k);
    return hit;
  endfunction

  function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_VIEW_X:   cam_x = data[4:0];
      REG_VIEW_Y:   cam_y = data[4:0];
      REG_VIEW_Z:   cam_z = data[4:0];
      REG_VIEW_DIR: facing = data[1:0];
      REG_HORIZON:  horizon = data;
      default: ;
    endcase
  endfunction

  function automatic cast_step_t cfg_op(input logic [CFG_IDX_W-1:0] idx,
                                        input logic [CFG_DATA_W-1:0] data);
    cast_step_t s;
    s = '{default: '0};
    s.is_cfg = 1'b1;
    s.idx = idx;
    s.data = data;
    return s;
  endfunction

  function automatic cast_step_t paint_op(input logic [4:0] x, input logic [4:0] y,
                                          input logic [4:0] z, input logic [7:0] color);
    cast_step_t s;
    s = '{default: '0};
    s.act = ACT_WRITE;
    s.x = x;
    s.y = y;
    s.z = z;
    s.color = color;
    return s;
  endfunction

  function automatic cast_step_t probe_op(input logic signed [6:0] row,
                                          input logic signed [6:0] col,
                                          input logic typed, input logic [7:0] want);
    cast_step_t s;
    s = '{default: '0};
    s.act = ACT_RENDER;
    s.row = row;
    s.col = col;
    s.typed = typed;
    s.want = want;
    return s;
  endfunction

  function automatic logic [4:0] near_coord(input logic [4:0] base);
    return base + 5'($urandom_range(0, 6)) - 5'd3;
  endfunction

  function automatic logic signed [6:0] pick_offset();
    if ($urandom_range(0, 4) != 0) return 7'(int'($urandom_range(0, 8)) - 4);
    return 7'($urandom);
  endfunction

  // Most items stay close to the camera's line of sight so that rays actually meet voxels.
  function automatic cast_step_t random_step();
    cast_step_t s;
    s = '{default: '0};
    s.x = 5'($urandom);
    s.y = 5'($urandom);
    s.z = 5'($urandom);
    s.color = ($urandom_range(0, 9) == 0) ? 8'h00 : 8'($urandom);
    s.row = 7'($urandom);
    s.col = 7'($urandom);
    if ($urandom_range(0, 99) < 35) begin
      s.act = ACT_WRITE;
      if ($urandom_range(0, 4) != 0) begin
        s.y = near_coord(cam_y);
        if (facing == DIR_FRONT || facing == DIR_BACK) s.x = near_coord(cam_x);
        else s.z = near_coord(cam_z);
      end
    end else begin
      s.act = ACT_RENDER;
      s.row = pick_offset();
      s.col = pick_offset();
    end
    return s;
  endfunction

  function automatic logic [4:0] pick_coord();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return '1;
      default: return 5'($urandom);
    endcase
  endfunction

  function automatic logic [6:0] pick_horizon();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return 7'd1;
      2: return 7'd64;
      3: return '1;
      default: return 7'($urandom_range(2, 40));
    endcase
  endfunction

  function automatic int idle_run();
    int n;
    n = 0;
    if (!steady) while ($urandom_range(0, 99) < 33) n++;
    return n;
  endfunction

  task automatic report_mismatch(input string what, input logic [7:0] want,
                                 input logic [7:0] got);
    errors++;
    if (errors <= 10)
      $display("Mismatch %0d at cycle %0d: %s, expected %02h, got %02h",
               errors, cycles, what, want, got);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    apply_reg(idx, data);
    n_cfg++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_item(input cast_step_t s);
    int gap;
    logic [7:0] want;
    gap = idle_run();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    action <= s.act;
    vox_x <= s.x;
    vox_y <= s.y;
    vox_z <= s.z;
    vox_color <= s.color;
    row_offset <= s.row;
    col_offset <= s.col;
    do @(posedge clk); while (!(in_valid && in_ready));
    if (s.act == ACT_WRITE) begin
      shade_map[(int'(s.z) * MAP_HEIGHT + int'(s.y)) * MAP_WIDTH + int'(s.x)] = s.color;
      n_paints++;
    end else begin
      want = s.typed ? s.want : cast_ray(s.row, s.col);
      pixel_q.push_back(want);
      n_probes++;
      if (want != 0) n_hits++;
    end
    items_sent = 1'b1;
  endtask

  // Registers change only with nothing in flight, so drain results and let a last march end.
  task automatic quiesce();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pixel_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    items_sent = 1'b0;
  endtask

  task automatic configure_phase(input int p);
    logic [1:0] dir;
    dir = (p < 8) ? 2'(p) : 2'($urandom);
    write_reg(REG_VIEW_X, {2'($urandom), pick_coord()});
    write_reg(REG_VIEW_Y, {2'($urandom), pick_coord()});
    write_reg(REG_VIEW_Z, {2'($urandom), pick_coord()});
    write_reg(REG_VIEW_DIR, {5'($urandom), dir});
    write_reg(REG_SPARE + 3'($urandom_range(0, 2)), 7'($urandom));
    write_reg(REG_HORIZON, pick_horizon());
  endtask

  always @(negedge clk) out_ready <= steady || ($urandom_range(0, 99) >= 33);

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pixel_q.size() == 0) report_mismatch("result with no render outstanding", '0,
                                               pixel_color);
      else if (pixel_color !== pixel_q[0]) report_mismatch("pixel_color", pixel_q[0],
                                                           pixel_color);
      if (pixel_q.size() != 0) void'(pixel_q.pop_front());
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding", cycles,
               pixel_q.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    action = ACT_WRITE;
    vox_x = '0;
    vox_y = '0;
    vox_z = '0;
    vox_color = '0;
    row_offset = '0;
    col_offset = '0;
    out_ready = 1'b0;
    steady = 1'b0;
    items_sent = 1'b0;
    errors = 0;
    cycles = 0;
    n_probes = 0;
    n_hits = 0;
    n_paints = 0;
    n_cfg = 0;
    foreach (shade_map[i]) shade_map[i] = '0;
    cam_x = '0;
    cam_y = '0;
    cam_z = '0;
    facing = DIR_FRONT;
    horizon = 7'd16;

    plan.push_back(probe_op(0, 0, 1'b1, 8'h00));
    plan.push_back(paint_op(5'd0, 5'd0, 5'd0, 8'hFF));
    plan.push_back(probe_op(0, 0, 1'b1, 8'hFF));
    plan.push_back(paint_op(5'd31, 5'd31, 5'd31, 8'h81));
    plan.push_back(paint_op(5'd31, 5'd31, 5'd0, 8'h42));
    plan.push_back(paint_op(5'd0, 5'd31, 5'd5, 8'h17));
    plan.push_back(probe_op(-64, 0, 1'b1, 8'h00));
    plan.push_back(probe_op(63, 63, 1'b1, 8'h00));
    plan.push_back(probe_op(0, -64, 1'b1, 8'h00));
    plan.push_back(cfg_op(REG_VIEW_X, 7'h7F));
    plan.push_back(cfg_op(REG_VIEW_Y, 7'd31));
    plan.push_back(cfg_op(REG_VIEW_Z, 7'd1));
    plan.push_back(cfg_op(REG_HORIZON, 7'h7F));
    plan.push_back(probe_op(0, 0, 1'b0, '0));
    plan.push_back(cfg_op(REG_VIEW_DIR, 7'(DIR_BACK)));
    plan.push_back(probe_op(0, 0, 1'b0, '0));
    plan.push_back(cfg_op(REG_VIEW_DIR, 7'(DIR_RIGHT)));
    plan.push_back(cfg_op(REG_VIEW_X, 7'd0));
    plan.push_back(cfg_op(REG_VIEW_Z, 7'd0));
    plan.push_back(probe_op(0, 31, 1'b0, '0));
    plan.push_back(cfg_op(REG_VIEW_DIR, 7'(DIR_LEFT)));
    plan.push_back(cfg_op(REG_VIEW_X, 7'd31));
    plan.push_back(probe_op(0, 5, 1'b0, '0));
    plan.push_back(cfg_op(REG_HORIZON, 7'd0));
    plan.push_back(probe_op(0, 5, 1'b0, '0));
    plan.push_back(cfg_op(REG_HORIZON, 7'd1));
    plan.push_back(probe_op(0, 5, 1'b0, '0));
    plan.push_back(cfg_op(REG_SPARE, 7'h7F));
    plan.push_back(cfg_op(REG_SPARE_LAST, 7'h00));
    plan.push_back(probe_op(0, 5, 1'b0, '0));
    plan.push_back(paint_op(5'd0, 5'd0, 5'd0, 8'h00));
    plan.push_back(cfg_op(REG_VIEW_DIR, 7'(DIR_FRONT)));
    plan.push_back(cfg_op(REG_VIEW_X, 7'd0));
    plan.push_back(cfg_op(REG_VIEW_Y, 7'd0));
    plan.push_back(cfg_op(REG_VIEW_Z, 7'd0));
    plan.push_back(cfg_op(REG_HORIZON, 7'd64));
    plan.push_back(probe_op(0, 0, 1'b0, '0));
    plan.push_back(probe_op(-1, -1, 1'b1, 8'h00));

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        if (items_sent) quiesce();
        write_reg(plan[i].idx, plan[i].data);
      end else begin
        send_item(plan[i]);
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      if (items_sent) quiesce();
      steady = (p == 6 || p == 7);
      configure_phase(p);
      repeat (PHASE_ITEMS) send_item(random_step());
    end
    steady = 1'b0;
    quiesce();

    if (pixel_q.size() != 0) report_mismatch("renders left without a result", '0, '0);
    $display("Covered %0d renders (%0d met a voxel), %0d voxel writes, %0d register writes.",
             n_probes, n_hits, n_paints, n_cfg);
    $display("Views in all four directions, horizons from zero to the top, %0d mismatches.",
             errors);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
